// ===== rtl/rvcg_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring vertex column generator package
// Shared widths, register indexes and CORDIC constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rvcg_pkg;

  localparam int SIGN_COUNT       = 12;
  localparam int MAX_SEGMENTS_DEF = 64;

  localparam int COL_W      = 10;
  localparam int RAD_W      = 16;
  localparam int SEGF_W     = 7;
  localparam int POS_W      = 17;
  localparam int TEX_W      = 17;
  localparam int SIGN_W     = 4;
  localparam int ANG_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int PHASE_W      = 24;
  localparam int TEX_FRAC     = 16;
  localparam int ANG_MUL      = 45;
  localparam int ANG_NUM_W    = 16;
  localparam int ANG_FRAC     = 11;
  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 32;
  localparam int ZW           = 25;
  localparam int TRIG_W       = 16;
  localparam int TRIG_MAX     = 32767;
  localparam int CORDIC_START = 652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER    = 2'd0,
    REG_OUTER    = 2'd1,
    REG_SEGMENTS = 2'd2
  } cfg_reg_t;

  function automatic logic [ZW-1:0] arc_angle(input int step);
    logic [ZW-1:0] a;
    case (step)
      0:       a = ZW'(2097152);
      1:       a = ZW'(1238021);
      2:       a = ZW'(654136);
      3:       a = ZW'(332050);
      4:       a = ZW'(166668);
      5:       a = ZW'(83416);
      6:       a = ZW'(41718);
      7:       a = ZW'(20860);
      8:       a = ZW'(10430);
      9:       a = ZW'(5215);
      10:      a = ZW'(2608);
      11:      a = ZW'(1304);
      12:      a = ZW'(652);
      13:      a = ZW'(326);
      14:      a = ZW'(163);
      15:      a = ZW'(81);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rvcg_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, integer bits then fraction bits, with remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvcg_div #(
  parameter int NUM_W = 10,
  parameter int FRAC  = 0,
  parameter int DEN_W = 10,
  parameter int PAD   = 0
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [NUM_W-1:0]       num,
  input  wire logic [DEN_W-1:0]       den,
  output logic      [NUM_W+FRAC-1:0]  quo,
  output logic      [DEN_W-1:0]       rem
);

  localparam int STEPS = NUM_W + FRAC;

  logic [DEN_W-1:0] rem_r [STEPS];
  logic [STEPS-1:0] q_r   [STEPS];
  logic [NUM_W-1:0] num_r [NUM_W-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [STEPS-1:0] q_in;
    logic             nb;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign nb     = num[NUM_W-1];
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      if (i < NUM_W) begin : g_bit
        assign nb = num_r[i-1][NUM_W-1-i];
      end else begin : g_zero
        assign nb = 1'b0;
      end
    end

    if (i < NUM_W - 1) begin : g_num
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[i] <= (i == 0) ? num : num_r[(i == 0) ? 0 : i-1];
        end
      end
    end

    assign trial = {rem_in, nb};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        q_r[i]   <= {q_in[STEPS-2:0], ge};
      end
    end
  end

  if (PAD > 0) begin : g_pad
    logic [STEPS-1:0] qp [PAD];
    logic [DEN_W-1:0] rp [PAD];
    for (genvar j = 0; j < PAD; j++) begin : g_dly
      always_ff @(posedge clk) begin
        if (en) begin
          qp[j] <= (j == 0) ? q_r[STEPS-1]   : qp[(j == 0) ? 0 : j-1];
          rp[j] <= (j == 0) ? rem_r[STEPS-1] : rp[(j == 0) ? 0 : j-1];
        end
      end
    end
    assign quo = qp[PAD-1];
    assign rem = rp[PAD-1];
  end else begin : g_nopad
    assign quo = q_r[STEPS-1];
    assign rem = rem_r[STEPS-1];
  end

endmodule

`default_nettype wire

// ===== rtl/rvcg_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC rotator
// One rotation per stage, then rounding to Q1.15 and quadrant mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvcg_cordic (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic        [rvcg_pkg::PHASE_W-1:0] phase,
  output logic signed      [rvcg_pkg::TRIG_W-1:0]  cos_q,
  output logic signed      [rvcg_pkg::TRIG_W-1:0]  sin_q
);
  import rvcg_pkg::*;

  logic signed [CW-1:0] x_r [CORDIC_STEPS];
  logic signed [CW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];
  logic        [1:0]    quad_r [CORDIC_STEPS];

  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] r;
    logic signed [TRIG_W-1:0] o;
    t = $signed({v[CW-1], v}) + $signed((CW+1)'(16384));
    r = t >>> 15;
    if (r > $signed((CW+1)'(TRIG_MAX))) begin
      o = TRIG_W'(TRIG_MAX);
    end else if (r < -$signed((CW+1)'(TRIG_MAX))) begin
      o = -TRIG_W'(TRIG_MAX);
    end else begin
      o = r[TRIG_W-1:0];
    end
    return o;
  endfunction

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic        [1:0]    q_in;
    logic                 d;

    if (i == 0) begin : g_first
      assign x_in = CW'(CORDIC_START);
      assign y_in = '0;
      assign z_in = $signed({{(ZW-PHASE_W+2){1'b0}}, phase[PHASE_W-3:0]});
      assign q_in = phase[PHASE_W-1:PHASE_W-2];
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign q_in = quad_r[i-1];
    end

    assign d = ~z_in[ZW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= d ? x_in - (y_in >>> i) : x_in + (y_in >>> i);
        y_r[i]    <= d ? y_in + (x_in >>> i) : y_in - (x_in >>> i);
        z_r[i]    <= d ? z_in - $signed(arc_angle(i)) : z_in + $signed(arc_angle(i));
        quad_r[i] <= q_in;
      end
    end
  end

  logic signed [TRIG_W-1:0] c;
  logic signed [TRIG_W-1:0] s;

  assign c = to_q15(x_r[CORDIC_STEPS-1]);
  assign s = to_q15(y_r[CORDIC_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_r[CORDIC_STEPS-1])
        2'd0:    begin cos_q <= c;  sin_q <= s;  end
        2'd1:    begin cos_q <= -s; sin_q <= c;  end
        2'd2:    begin cos_q <= -c; sin_q <= -s; end
        default: begin cos_q <= s;  sin_q <= -c; end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ring_vertex_column_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Ring vertex column generator
// Inner and outer ring vertex positions, texture u, sign, angle and in-range flag per column.
// ----------------------------------------------------------------------------
// One column beat enters on in_valid while in_stall is low; one result beat
// leaves on out_valid and is taken when out_stall is low.
// A new column can enter in every cycle unless a waiting result is stalled, so the
// throughput is one column per cycle. The path is an input register, a 34-stage restoring
// divider (one quotient bit per stage), a rounding stage, a 16-stage CORDIC
// with a mapping stage, a multiply stage and the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Radii and the segment count are written through the cfg port (cfg_ready is
// always high); the user must write them only while no column is in flight.
// The block does not enforce it. Reset empties the pipeline and sets inner
// radius 1.0, outer radius 2.0 and one segment per sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_vertex_column_generator_unit #(
  parameter int MAX_SEGMENTS = rvcg_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rvcg_pkg::COL_W-1:0]        column,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [rvcg_pkg::POS_W-1:0]      inner_x,
  output logic signed [rvcg_pkg::POS_W-1:0]      inner_z,
  output logic signed [rvcg_pkg::POS_W-1:0]      outer_x,
  output logic signed [rvcg_pkg::POS_W-1:0]      outer_z,
  output logic [rvcg_pkg::TEX_W-1:0]             tex_u,
  output logic [rvcg_pkg::SIGN_W-1:0]            sign_number,
  output logic [rvcg_pkg::ANG_W-1:0]             angle_degrees,
  output logic                                   in_range,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rvcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rvcg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rvcg_pkg::*;

  localparam int SEG_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int TOT_W   = $clog2(SIGN_COUNT * MAX_SEGMENTS + 1);
  localparam int DIV_LAT = COL_W + PHASE_W;
  localparam int SIDE_N  = CORDIC_STEPS + 3;
  localparam int V_N     = DIV_LAT + 1 + SIDE_N + 1;
  localparam int PROD_W  = RAD_W + 1 + TRIG_W;
  localparam int UQ_W    = COL_W + TEX_FRAC;
  localparam int AQ_W    = ANG_NUM_W + ANG_FRAC;

  typedef struct packed {
    logic [TEX_W-1:0]  u;
    logic [SIGN_W-1:0] sgn;
    logic [ANG_W-1:0]  ang;
    logic              inr;
  } side_t;

  logic [RAD_W-1:0]  inner_rad;
  logic [RAD_W-1:0]  outer_rad;
  logic [SEGF_W-1:0] segments_each_sign;

  logic [SEG_W-1:0] seg_eff;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] half;

  logic en;
  logic accept;
  logic v [V_N];

  logic [COL_W-1:0]     col_r;
  logic [ANG_NUM_W-1:0] col45_r;
  logic                 inr_d [DIV_LAT+1];

  logic [DIV_LAT-1:0] q_p;
  logic [TOT_W-1:0]   r_p;
  logic [UQ_W-1:0]    q_u;
  logic [TOT_W-1:0]   r_u;
  logic [AQ_W-1:0]    q_a;
  logic [TOT_W-1:0]   r_a;
  logic [COL_W-1:0]   q_s;
  logic [SEG_W-1:0]   r_s;

  logic [PHASE_W-1:0] phase;
  side_t              side_r [SIDE_N+1];
  side_t              side_next;

  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;
  logic signed [PROD_W-1:0] p_ix, p_iz, p_ox, p_oz;

  function automatic logic signed [POS_W-1:0] round_pos(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    logic signed [PROD_W:0] r;
    t = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(16384));
    r = t >>> 15;
    return r[POS_W-1:0];
  endfunction

  function automatic logic rnd_up(input logic [TOT_W-1:0] r, input logic [TOT_W-1:0] h,
                                  input logic [TOT_W-1:0] t);
    return ({1'b0, r} + {1'b0, h}) >= {1'b0, t};
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_rad          <= RAD_W'(256);
      outer_rad          <= RAD_W'(512);
      segments_each_sign <= SEGF_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INNER:    inner_rad          <= cfg_data[RAD_W-1:0];
        REG_OUTER:    outer_rad          <= cfg_data[RAD_W-1:0];
        REG_SEGMENTS: segments_each_sign <= cfg_data[SEGF_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    if (segments_each_sign == '0) begin
      seg_eff = SEG_W'(1);
    end else if (segments_each_sign > SEGF_W'(MAX_SEGMENTS)) begin
      seg_eff = SEG_W'(MAX_SEGMENTS);
    end else begin
      seg_eff = SEG_W'(segments_each_sign);
    end
  end

  assign total = TOT_W'(seg_eff * SIGN_COUNT);
  assign half  = total >> 1;

  assign en        = ~v[V_N-1] | ~out_stall;
  assign in_stall  = ~en;
  assign accept    = in_valid & en;
  assign out_valid = v[V_N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < V_N; k++) begin
        v[k] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= accept;
      for (int k = 1; k < V_N; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r    <= column;
      col45_r  <= ANG_NUM_W'({{(ANG_NUM_W-COL_W){1'b0}}, column} * ANG_NUM_W'(ANG_MUL));
      inr_d[0] <= ((COL_W+TOT_W)'(column) <= (COL_W+TOT_W)'(total));
      for (int k = 1; k <= DIV_LAT; k++) begin
        inr_d[k] <= inr_d[k-1];
      end
    end
  end

  rvcg_div #(.NUM_W(COL_W), .FRAC(PHASE_W), .DEN_W(TOT_W), .PAD(0)) u_div_phase (
    .clk(clk), .en(en), .num(col_r), .den(total), .quo(q_p), .rem(r_p)
  );

  rvcg_div #(.NUM_W(COL_W), .FRAC(TEX_FRAC), .DEN_W(TOT_W), .PAD(DIV_LAT - UQ_W)) u_div_tex (
    .clk(clk), .en(en), .num(col_r), .den(total), .quo(q_u), .rem(r_u)
  );

  rvcg_div #(.NUM_W(ANG_NUM_W), .FRAC(ANG_FRAC), .DEN_W(TOT_W), .PAD(DIV_LAT - AQ_W)) u_div_ang (
    .clk(clk), .en(en), .num(col45_r), .den(total), .quo(q_a), .rem(r_a)
  );

  rvcg_div #(.NUM_W(COL_W), .FRAC(0), .DEN_W(SEG_W), .PAD(DIV_LAT - COL_W)) u_div_sign (
    .clk(clk), .en(en), .num(col_r), .den(seg_eff), .quo(q_s), .rem(r_s)
  );

  logic [UQ_W:0] u_full;
  logic [AQ_W:0] a_full;

  always_comb begin
    u_full = {1'b0, q_u} + (UQ_W+1)'(rnd_up(r_u, half, total));
    a_full = {1'b0, q_a} + (AQ_W+1)'(rnd_up(r_a, half, total));
    side_next.u   = (u_full > (UQ_W+1)'({TEX_W{1'b1}})) ? {TEX_W{1'b1}} : u_full[TEX_W-1:0];
    side_next.ang = (a_full > (AQ_W+1)'({ANG_W{1'b1}})) ? {ANG_W{1'b1}} : a_full[ANG_W-1:0];
    side_next.sgn = (q_s > COL_W'(SIGN_COUNT - 1) || r_s > seg_eff) ?
                    SIGN_W'(SIGN_COUNT - 1) : q_s[SIGN_W-1:0];
    side_next.inr = inr_d[DIV_LAT];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase     <= q_p[PHASE_W-1:0] + PHASE_W'(rnd_up(r_p, half, total));
      side_r[0] <= side_next;
      for (int k = 1; k <= SIDE_N; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  rvcg_cordic u_cordic (
    .clk(clk), .en(en), .phase(phase), .cos_q(cos_q), .sin_q(sin_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p_ix <= $signed({1'b0, inner_rad}) * cos_q;
      p_iz <= $signed({1'b0, inner_rad}) * sin_q;
      p_ox <= $signed({1'b0, outer_rad}) * cos_q;
      p_oz <= $signed({1'b0, outer_rad}) * sin_q;
      inner_x <= round_pos(p_ix);
      inner_z <= round_pos(p_iz);
      outer_x <= round_pos(p_ox);
      outer_z <= round_pos(p_oz);
    end
  end

  assign tex_u         = side_r[SIDE_N].u;
  assign sign_number   = side_r[SIDE_N].sgn;
  assign angle_degrees = side_r[SIDE_N].ang;
  assign in_range      = side_r[SIDE_N].inr;

endmodule

`default_nettype wire

// ===== bench/ring_vertex_column_checker.sv =====
// ----------------------------------------------------------------------------
// Ring vertex column checker
// Watches the column, result and register channels of the generator, works
// out the expected vertex column for every accepted column beat and compares
// each accepted result beat with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ring_vertex_column_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [rvcg_pkg::COL_W-1:0]           column,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [rvcg_pkg::POS_W-1:0]    inner_x,
  input  logic signed [rvcg_pkg::POS_W-1:0]    inner_z,
  input  logic signed [rvcg_pkg::POS_W-1:0]    outer_x,
  input  logic signed [rvcg_pkg::POS_W-1:0]    outer_z,
  input  logic [rvcg_pkg::TEX_W-1:0]           tex_u,
  input  logic [rvcg_pkg::SIGN_W-1:0]          sign_number,
  input  logic [rvcg_pkg::ANG_W-1:0]           angle_degrees,
  input  logic                                 in_range,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [rvcg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rvcg_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   errors,
  output int                                   pending,
  output int                                   columns_done
);
  import rvcg_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  ix;
    logic [POS_W-1:0]  iz;
    logic [POS_W-1:0]  ox;
    logic [POS_W-1:0]  oz;
    logic [TEX_W-1:0]  u;
    logic [SIGN_W-1:0] sgn;
    logic [ANG_W-1:0]  ang;
    logic              rng;
  } vertex_col_t;

  localparam longint ARCTAN [CORDIC_STEPS] = '{
    2097152, 1238021, 654136, 332050, 166668, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  logic [RAD_W-1:0]  inner_rad;
  logic [RAD_W-1:0]  outer_rad;
  logic [SEGF_W-1:0] seg_reg;
  vertex_col_t       expected_cols[$];

  function automatic longint round_trig(longint v);
    longint r;
    r = (v + (64'sd1 <<< 14)) >>> 15;
    if (r > TRIG_MAX) r = longint'(TRIG_MAX);
    if (r < -TRIG_MAX) r = -longint'(TRIG_MAX);
    return r;
  endfunction

  function automatic logic [POS_W-1:0] place(longint radius, longint trig);
    longint p;
    p = (radius * trig + (64'sd1 <<< 14)) >>> 15;
    return p[POS_W-1:0];
  endfunction

  function automatic vertex_col_t vertex_of(logic [COL_W-1:0] col);
    vertex_col_t v;
    longint seg, total, half, ph, z, x, y, dx, dy, c, s, cq, sq, u, ang, sg;
    logic [1:0] quad;
    seg = longint'(seg_reg);
    if (seg < 1) seg = 1;
    if (seg > MAX_SEGMENTS_DEF) seg = longint'(MAX_SEGMENTS_DEF);
    total = longint'(SIGN_COUNT) * seg;
    half = total / 2;
    ph = (((longint'(col)) << PHASE_W) + half) / total;
    ph = ph & ((64'sd1 << PHASE_W) - 1);
    quad = ph[PHASE_W-1 -: 2];
    z = ph & ((64'sd1 << (PHASE_W - 2)) - 1);
    x = longint'(CORDIC_START);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN[i];
      end
    end
    c = round_trig(x);
    s = round_trig(y);
    case (quad)
      2'd0: begin cq = c;  sq = s;  end
      2'd1: begin cq = -s; sq = c;  end
      2'd2: begin cq = -c; sq = -s; end
      default: begin cq = s; sq = -c; end
    endcase
    u = (((longint'(col)) << 16) + half) / total;
    if (u > 131071) u = 131071;
    ang = (longint'(col) * 92160 + half) / total;
    if (ang > 262143) ang = 262143;
    sg = longint'(col) / seg;
    if (sg > SIGN_COUNT - 1) sg = longint'(SIGN_COUNT - 1);
    v.ix  = place(longint'(inner_rad), cq);
    v.iz  = place(longint'(inner_rad), sq);
    v.ox  = place(longint'(outer_rad), cq);
    v.oz  = place(longint'(outer_rad), sq);
    v.u   = u[TEX_W-1:0];
    v.sgn = sg[SIGN_W-1:0];
    v.ang = ang[ANG_W-1:0];
    v.rng = (longint'(col) <= total);
    return v;
  endfunction

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  assign pending = expected_cols.size();

  always @(posedge clk) begin
    vertex_col_t e;
    if (rst) begin
      inner_rad <= 16'd256;
      outer_rad <= 16'd512;
      seg_reg <= 7'd1;
      expected_cols.delete();
      errors <= 0;
      columns_done <= 0;
    end else begin
      if (in_valid && !in_stall) expected_cols.push_back(vertex_of(column));
      if (out_valid && !out_stall) begin
        columns_done <= columns_done + 1;
        if (expected_cols.size() == 0) begin
          errors++;
          $display("%0t: result beat with no column waiting", $time);
        end else begin
          e = expected_cols.pop_front();
          compare_field("inner_x", longint'(signed'(e.ix)), longint'(inner_x));
          compare_field("inner_z", longint'(signed'(e.iz)), longint'(inner_z));
          compare_field("outer_x", longint'(signed'(e.ox)), longint'(outer_x));
          compare_field("outer_z", longint'(signed'(e.oz)), longint'(outer_z));
          compare_field("tex_u", longint'(e.u), longint'(tex_u));
          compare_field("sign_number", longint'(e.sgn), longint'(sign_number));
          compare_field("angle_degrees", longint'(e.ang), longint'(angle_degrees));
          compare_field("in_range", longint'(e.rng), longint'(in_range));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_INNER:    inner_rad <= cfg_data;
          REG_OUTER:    outer_rad <= cfg_data;
          REG_SEGMENTS: seg_reg <= cfg_data[SEGF_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/ring_vertex_column_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Ring vertex column generator testbench
// Drives directed and random column beats through several radius and segment
// settings with random idling and stalls on both sides; the checker judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ring_vertex_column_generator_unit_tb;
  import rvcg_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [COL_W-1:0] column = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready, in_range;
  logic signed [POS_W-1:0] inner_x, inner_z, outer_x, outer_z;
  logic [TEX_W-1:0] tex_u;
  logic [SIGN_W-1:0] sign_number;
  logic [ANG_W-1:0] angle_degrees;
  int errors, pending, columns_done;
  int tx_idle_pct = 9;
  int rx_stall_pct = 56;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int cycles = 0;
  int seg_now = 1;
  int settings_done = 0;

  always #5 clk = ~clk;

  ring_vertex_column_generator_unit dut (.*);

  ring_vertex_column_checker chk (.*);

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("ring_vertex_column_generator_unit test failed");
      $finish;
    end
  end

  task automatic send_column(logic [COL_W-1:0] c);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    column <= c;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    logic taken;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    if (idx == REG_SEGMENTS) begin
      seg_now = (val[SEGF_W-1:0] == 0) ? 1 :
                (int'(val[SEGF_W-1:0]) > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF :
                int'(val[SEGF_W-1:0]);
      settings_done++;
    end
  endtask

  task automatic set_ring(int ri, int ro, int sg);
    write_reg(REG_INNER, ri[15:0]);
    write_reg(REG_OUTER, ro[15:0]);
    write_reg(REG_SEGMENTS, sg[15:0]);
  endtask

  task automatic random_columns(int n);
    int total;
    total = 12 * seg_now;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if ($urandom_range(99) < 80) begin
        send_column(COL_W'($urandom_range(total > 1023 ? 1023 : total)));
      end else begin
        send_column(COL_W'($urandom_range(1023)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int c = 0; c <= 13; c++) send_column(COL_W'(c));
    send_column(10'd511);
    send_column(10'd1023);
    set_ring(0, 65535, 0);
    send_column(10'd3);
    send_column(10'd12);
    set_ring(65535, 65535, 127);
    send_column(10'd768);
    send_column(10'd769);
    send_column(10'd1023);
    set_ring(65535, 0, 64);
    send_column(10'd0);
    send_column(10'd767);
    send_column(10'd384);
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin tx_idle_pct = 56; rx_stall_pct = 9; end
      if (p == 6) begin tx_idle_pct = 0; rx_stall_pct = 0; end
      if (p % 3 == 0) set_ring($urandom_range(65535), $urandom_range(65535), $urandom_range(1, 6));
      else if (p % 3 == 1) set_ring($urandom_range(2048), $urandom_range(65535),
                                    $urandom_range(127));
      else set_ring($urandom_range(65535), $urandom_range(512), $urandom_range(60, 64));
      if (p == 1) hold_seq <= hold_seq + 1;
      random_columns(185);
    end
    drain();
    $display("Covered %0d result beats over %0d segment settings,", columns_done,
             settings_done);
    $display("with random idling, stalls and one long receiver hold-off.");
    if (errors == 0) begin
      $display("ring_vertex_column_generator_unit test passed");
    end else begin
      $display("ring_vertex_column_generator_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rvcg_pkg.sv
rtl/rvcg_div.sv
rtl/rvcg_cordic.sv
rtl/ring_vertex_column_generator_unit.sv
bench/ring_vertex_column_checker.sv
bench/ring_vertex_column_generator_unit_tb.sv
